FILE: rtl/core/bra_pkg.sv
// Shared types and constants of the bitmap run allocator.
`default_nettype none

package bra_pkg;

  // Default number of bitmap bytes held in the store.
  localparam int unsigned MAP_BYTES_DEFAULT = 256;

  // Request codes carried on func.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_TEST  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_SCAN  = 2'd3;

  // Register value after reset: the whole default store is in use.
  localparam logic [8:0] BYTES_IN_USE_RESET = 9'd256;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST,
    ST_WRITE,
    ST_SCAN
  } bra_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bitmap_run_allocator_core.sv
// First-fit bitmap allocator: usage store, request sequencer and byte-serial run search.
`default_nettype none

// Usage:
// A request is a transfer on start/busy: it is taken at a rising clock edge with start
// high and busy low, and carries func, bit_index, set_value and run_length. Every
// request gives exactly one result, shown on found, start_index and bit_value for a
// single cycle while done is high. The receiver cannot stall, so it must take the
// result in that cycle.
// A bit test or a bit write first reads the store, then does the read-modify-write or
// takes the tested bit, and issues its result. A scan walks the store one byte per cycle
// through the single read port and its byte-wide run counter, over the first N bytes,
// where N is the smaller of bytes_in_use and MAP_BYTES. Clear-all sweeps the store one
// byte a cycle. Only one request is in work at a time; busy stays high until its result
// is issued.
// Reset runs the same clearing sweep with busy high and no result, and loads
// bytes_in_use with 256. The user must write the register with cfg_we and cfg_wdata
// only while no request is in work; the block itself does not enforce this.
module bitmap_run_allocator_core #(
  parameter int unsigned MAP_BYTES = bra_pkg::MAP_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [10:0] bit_index,
  input  logic        set_value,
  input  logic [11:0] run_length,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  output logic        done,
  output logic        found,
  output logic [10:0] start_index,
  output logic        bit_value
);

  import bra_pkg::*;

  localparam int unsigned AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned STORE_BITS = MAP_BYTES * 8;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

  // Usage store, one byte per entry, bit b of the map at byte b/8, position b%8.
  logic [7:0]    mem [MAP_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  bra_state_t    state, state_next;
  logic [8:0]    bytes_in_use;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          clr_ack, clr_ack_next;
  logic [10:0]   op_index, op_index_next;
  logic          op_value, op_value_next;
  logic          op_in_store, op_in_store_next;
  logic [11:0]   want, want_next;
  logic [8:0]    scan_limit, scan_limit_next;
  logic [8:0]    rd_byte, rd_byte_next;
  logic [8:0]    proc_byte, proc_byte_next;
  logic          pend, pend_next;
  logic [11:0]   cnt, cnt_next;
  logic          done_next, found_next, bit_value_next;
  logic [10:0]   start_index_next;

  // Run counter applied to one byte of read data.
  logic [11:0]   run_cnt;
  logic          hit;
  logic [2:0]    hit_pos;
  logic [10:0]   hit_start;
  logic [7:0]    byte_mod;

  assign busy = (state != ST_IDLE);

  // Store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Walk the eight bits of the byte in hand, counting consecutive free bits. The count
  // carries over from the previous byte, and the first bit at which it reaches the
  // wanted length ends the run. Bits before the first free bit are all used, so a plain
  // count from bit zero finds the same run as a search that begins at that bit.
  always_comb begin
    run_cnt = cnt;
    hit     = 1'b0;
    hit_pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!hit) begin
        if (mem_rdata[i]) begin
          run_cnt = 12'd0;
        end else begin
          run_cnt = run_cnt + 12'd1;
          if (run_cnt == want) begin
            hit     = 1'b1;
            hit_pos = 3'(i);
          end
        end
      end
    end
    // The run start is the end bit plus one less the length; the result keeps 11 bits,
    // so the sum is formed modulo 2^11.
    hit_start = 11'({proc_byte, hit_pos}) + 11'd1 - 11'(want);
  end

  // Byte with the addressed bit replaced, for the read-modify-write of a bit write.
  always_comb begin
    byte_mod = mem_rdata;
    byte_mod[op_index[2:0]] = op_value;
  end

  // Sequencer: next state, store control and the result of each request.
  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    clr_ack_next     = clr_ack;
    op_index_next    = op_index;
    op_value_next    = op_value;
    op_in_store_next = op_in_store;
    want_next        = want;
    scan_limit_next  = scan_limit;
    rd_byte_next     = rd_byte;
    proc_byte_next   = proc_byte;
    pend_next        = pend;
    cnt_next         = cnt;
    done_next        = 1'b0;
    found_next       = 1'b1;
    start_index_next = 11'd0;
    bit_value_next   = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = clr_addr;
    mem_wdata        = 8'd0;
    mem_raddr        = AW'(bit_index[10:3]);

    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'd0;
        if (clr_addr == LAST_ADDR) begin
          state_next   = ST_IDLE;
          done_next    = clr_ack;
          clr_ack_next = 1'b0;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_index_next    = bit_index;
          op_value_next    = set_value;
          op_in_store_next = (32'(bit_index) < STORE_BITS);
          want_next        = (run_length == 12'd0) ? 12'd1 : run_length;
          scan_limit_next  = (32'(bytes_in_use) > MAP_BYTES) ? 9'(MAP_BYTES) : bytes_in_use;
          rd_byte_next     = 9'd0;
          pend_next        = 1'b0;
          cnt_next         = 12'd0;
          case (func)
            FUNC_CLEAR: begin
              state_next    = ST_CLEAR;
              clr_addr_next = '0;
              clr_ack_next  = 1'b1;
            end
            FUNC_TEST:  state_next = ST_TEST;
            FUNC_WRITE: state_next = ST_WRITE;
            default:    state_next = ST_SCAN;
          endcase
        end
      end

      ST_TEST: begin
        done_next      = 1'b1;
        bit_value_next = op_in_store & mem_rdata[op_index[2:0]];
        state_next     = ST_IDLE;
      end

      ST_WRITE: begin
        mem_we     = op_in_store;
        mem_waddr  = AW'(op_index[10:3]);
        mem_wdata  = byte_mod;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      ST_SCAN: begin
        mem_raddr = AW'(rd_byte);
        if (pend) begin
          cnt_next = run_cnt;
        end
        if (pend && hit) begin
          done_next        = 1'b1;
          start_index_next = hit_start;
          state_next       = ST_IDLE;
        end else if (rd_byte >= scan_limit) begin
          // Every byte in use has been searched without a long enough run.
          done_next  = 1'b1;
          found_next = 1'b0;
          state_next = ST_IDLE;
        end else begin
          pend_next      = 1'b1;
          proc_byte_next = rd_byte;
          rd_byte_next   = rd_byte + 9'd1;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      clr_ack      <= 1'b0;
      pend         <= 1'b0;
      done         <= 1'b0;
      bytes_in_use <= BYTES_IN_USE_RESET;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      clr_ack  <= clr_ack_next;
      pend     <= pend_next;
      done     <= done_next;
      if (cfg_we) begin
        bytes_in_use <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_index    <= op_index_next;
    op_value    <= op_value_next;
    op_in_store <= op_in_store_next;
    want        <= want_next;
    scan_limit  <= scan_limit_next;
    rd_byte     <= rd_byte_next;
    proc_byte   <= proc_byte_next;
    cnt         <= cnt_next;
    found       <= found_next;
    start_index <= start_index_next;
    bit_value   <= bit_value_next;
  end

  // A result only ever follows a cycle in which a request was in work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result issued without a request in work");

  // An accepted request always raises busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A failed scan reports neither a run start nor a tested bit.
  a_not_found_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (start_index == 11'd0 && !bit_value))
    else $error("failed scan carries a nonzero payload");

endmodule

`default_nettype wire
